@@ sv/rpn_pkg.sv @@
// ---------------------------------------------------------------------------
// rpn_pkg: shared types and constants of the RPN stack calculator
// Operation codes, word widths and the control bundle of the serial ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

   // operand word and result depth field
   localparam int WORD_W      = 32;
   localparam int DEPTH_OUT_W = 10;
   localparam int CNT_W       = $clog2(WORD_W);

   // operation codes
   localparam logic [2:0] OP_ENTER = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_SUB   = 3'd2;
   localparam logic [2:0] OP_MUL   = 3'd3;
   localparam logic [2:0] OP_DIV   = 3'd4;

   // start strobe and operation for the serial ALU
   typedef struct packed {
      logic       start;
      logic [2:0] op;
   } alu_ctl_type;

endpackage

`default_nettype wire

@@ sv/rpn_alu.sv @@
// ---------------------------------------------------------------------------
// rpn_alu: serial arithmetic unit
// Add and subtract one bit per cycle through shift registers; multiply by
// shift-and-add and divide by restoring steps, one radix-2 step per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_alu
   import rpn_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  alu_ctl_type        ctl,
   input  wire [WORD_W-1:0]   opa,
   input  wire [WORD_W-1:0]   opb,
   output logic               done,
   output logic [WORD_W-1:0]  result
);

   typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIN} alu_state_type;

   alu_state_type     state_ff;
   logic [2:0]        op_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WORD_W-1:0] x_ff;      // addend / multiplicand / dividend-quotient
   logic [WORD_W-1:0] y_ff;      // addend / multiplier / divisor
   logic [WORD_W:0]   acc_ff;    // sum / product / remainder
   logic              carry_ff;
   logic              neg_ff;
   logic              done_ff;
   logic [WORD_W-1:0] result_ff;

   logic              sub_mode;
   logic              b_bit;
   logic              s_bit;
   logic              c_out;
   logic [WORD_W-1:0] prod_sum;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;
   logic [WORD_W-1:0] quot;

   // per-step datapath
   always_comb begin
      sub_mode = (op_ff == OP_SUB);
      b_bit    = y_ff[0] ^ sub_mode;
      s_bit    = x_ff[0] ^ b_bit ^ carry_ff;
      c_out    = (x_ff[0] & b_bit) | (x_ff[0] & carry_ff) | (b_bit & carry_ff);
      prod_sum = acc_ff[WORD_W-1:0] + (y_ff[0] ? x_ff : '0);
      trial    = {acc_ff[WORD_W-1:0], x_ff[WORD_W-1]};
      diff     = trial - {1'b0, y_ff};
      quot     = neg_ff ? ('0 - x_ff) : x_ff;
   end

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            A_IDLE: begin
               if (ctl.start) begin
                  op_ff    <= ctl.op;
                  cnt_ff   <= '0;
                  acc_ff   <= '0;
                  carry_ff <= (ctl.op == OP_SUB);
                  neg_ff   <= opa[WORD_W-1] ^ opb[WORD_W-1];
                  if (ctl.op == OP_DIV) begin
                     x_ff <= opa[WORD_W-1] ? ('0 - opa) : opa;
                     y_ff <= opb[WORD_W-1] ? ('0 - opb) : opb;
                  end else begin
                     x_ff <= opa;
                     y_ff <= opb;
                  end
                  state_ff <= A_RUN;
               end
            end
            A_RUN: begin
               case (op_ff) inside
                  OP_ADD, OP_SUB: begin
                     acc_ff   <= {1'b0, s_bit, acc_ff[WORD_W-1:1]};
                     carry_ff <= c_out;
                     x_ff     <= x_ff >> 1;
                     y_ff     <= y_ff >> 1;
                  end
                  OP_MUL: begin
                     acc_ff <= {1'b0, prod_sum};
                     x_ff   <= x_ff << 1;
                     y_ff   <= y_ff >> 1;
                  end
                  default: begin
                     // restoring divide step
                     acc_ff <= diff[WORD_W] ? trial : diff;
                     x_ff   <= {x_ff[WORD_W-2:0], ~diff[WORD_W]};
                  end
               endcase
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(WORD_W - 1)) begin
                  state_ff <= A_FIN;
               end
            end
            A_FIN: begin
               result_ff <= (op_ff == OP_DIV) ? quot : acc_ff[WORD_W-1:0];
               done_ff   <= 1'b1;
               state_ff  <= A_IDLE;
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

@@ sv/rpn_stack_calculator.sv @@
// ---------------------------------------------------------------------------
// rpn_stack_calculator: Reverse-Polish calculator core
// Optional push, then add/sub/mul/div on the two topmost stack entries.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser
//  req_    | in  | [31:0] number                  | [0] has_number, [3:1] req_type
//  rsp_    | out | [31:0] top_value, [41:32]      | -
//          |     | depth, [42] computed,          |
//          |     | [43] div_by_zero, [47:44] zero |
//
//  One beat in, one beat out. An arithmetic op runs through the 32 serial
//  steps of the ALU.
//  Items are worked one at a time; the next beat is taken once the result
//  sits in the output register, even while that register is stalled.
//  Synchronous active-high reset empties the stack; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = 512
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,    // [31:0] number
   input  wire  [3:0]  req_tuser,    // [0] has_number, [3:1] req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata     // [31:0] top_value, [41:32] depth,
                                     // [42] computed, [43] div_by_zero
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_PUSH, S_CHECK, S_START, S_CALC, S_WRITE, S_OUT
   } state_type;

   state_type          state_ff;
   logic               has_ff;
   logic [WORD_W-1:0]  number_ff;
   logic [2:0]         type_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [WORD_W-1:0]  top_ff;
   logic               computed_ff;
   logic               dz_ff;
   logic               rsp_valid_ff;
   logic [47:0]        rsp_data_ff;

   logic [WORD_W-1:0]  mem [STACK_DEPTH];
   logic [WORD_W-1:0]  rd_data_ff;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [DEPTH_W-1:0] below_addr;

   alu_ctl_type        alu_ctl;
   logic               alu_done;
   logic [WORD_W-1:0]  alu_result;

   logic               is_arith;
   logic [DEPTH_W+DEPTH_OUT_W-1:0] depth_wide;
   logic [WORD_W-1:0]  top_out;

   assign below_addr = depth_ff - DEPTH_W'(2);
   assign is_arith   = (type_ff == OP_ADD) || (type_ff == OP_SUB) ||
                       (type_ff == OP_MUL) || (type_ff == OP_DIV);
   assign depth_wide = {{DEPTH_OUT_W{1'b0}}, depth_ff};
   assign top_out    = (depth_ff != '0) ? top_ff : '0;

   // stack write port: push or result write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = depth_ff[ADDR_W-1:0];
      wr_data = number_ff;
      if (state_ff == S_PUSH) begin
         wr_en = has_ff && (depth_ff < DEPTH_W'(STACK_DEPTH));
      end else if (state_ff == S_WRITE) begin
         wr_en   = 1'b1;
         wr_addr = below_addr[ADDR_W-1:0];
         wr_data = alu_result;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // left operand read, one below the top
   always_ff @(posedge clock) begin
      if (state_ff == S_CHECK) begin
         rd_data_ff <= mem[below_addr[ADDR_W-1:0]];
      end
   end

   // serial ALU
   assign alu_ctl.start = (state_ff == S_START);
   assign alu_ctl.op    = type_ff;

   rpn_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .opa    (rd_data_ff),
      .opb    (top_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   // sequencer, stack pointer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  has_ff      <= req_tuser[0];
                  type_ff     <= req_tuser[3:1];
                  number_ff   <= req_tdata;
                  computed_ff <= 1'b0;
                  dz_ff       <= 1'b0;
                  state_ff    <= S_PUSH;
               end
            end
            S_PUSH: begin
               // a push onto a full stack is dropped
               if (has_ff && (depth_ff < DEPTH_W'(STACK_DEPTH))) begin
                  depth_ff <= depth_ff + DEPTH_W'(1);
                  top_ff   <= number_ff;
               end
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (is_arith && (depth_ff >= DEPTH_W'(2))) begin
                  if ((type_ff == OP_DIV) && (top_ff == '0)) begin
                     dz_ff    <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_START;
                  end
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_START: begin
               state_ff <= S_CALC;
            end
            S_CALC: begin
               if (alu_done) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               depth_ff    <= depth_ff - DEPTH_W'(1);
               top_ff      <= alu_result;
               computed_ff <= 1'b1;
               state_ff    <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {4'b0, dz_ff, computed_ff,
                                   depth_wide[DEPTH_OUT_W-1:0], top_out};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[42] && rsp_data_ff[43]))
      else $error("computed and div_by_zero both set");

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == S_CALC))
      else $error("ALU result with no operation pending");

   a_computed_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[42]) |-> (depth_ff != '0))
      else $error("computed result with empty stack");

endmodule

`default_nettype wire

@@ bench/tb_rpn_stack_calculator.sv @@
// ---------------------------------------------------------------------------
// tb_rpn_stack_calculator: self-checking bench for the RPN calculator core
// Walks a short script of keypad entries, then random entries in which the
// stack is filled past full and drained again. Each response beat is checked
// field by field against the script's typed readout or an in-bench stack model.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_rpn_stack_calculator
   import rpn_pkg::*;
();

   localparam int STACK_DEPTH = 512;
   localparam int TOTAL_KEYS  = 1500;
   localparam int FILL_AT     = 325;   // entry count at which the stack gets filled
   localparam int QUIET_KEYS  = 150;   // tail of the run with no idling
   localparam int HOLD_AFTER  = 300;   // response beats seen before the long stall
   localparam int HOLD_CYCLES = 500;
   localparam int SCRIPT_LEN  = 25;

   // codes outside the defined operations
   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   typedef struct packed {
      logic        has_number;
      logic [31:0] number;
      logic [2:0]  op;
   } key_type;

   typedef struct packed {
      logic [31:0] top;
      logic [9:0]  depth;
      logic        computed;
      logic        div_by_zero;
   } readout_type;

   // script row: entry, then a typed readout where one is given
   typedef struct packed {
      logic        has_number;
      logic [31:0] number;
      logic [2:0]  op;
      logic        typed;
      logic [31:0] top;
      logic [9:0]  depth;
      logic        computed;
      logic        div_by_zero;
   } script_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] number
   logic [3:0]  req_tuser  = '0;   // [0] has_number, [3:1] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [31:0] top_value, [41:32] depth,
                                   // [42] computed, [43] div_by_zero

   // model of the operand stack
   logic [31:0] calc_stack [STACK_DEPTH];
   int          stack_fill = 0;

   readout_type expected_readouts [$];
   int          error_count   = 0;
   int          readouts_seen = 0;
   int          keys_offered  = 0;
   bit          quiet         = 1'b0;

   script_row_type key_script [SCRIPT_LEN] = '{
      // empty stack after reset
      '{1'b0, 32'h0000_0000, OP_ENTER, 1'b1, 32'h0000_0000, 10'd0, 1'b0, 1'b0},
      '{1'b0, 32'h0000_0000, OP_ADD,   1'b1, 32'h0000_0000, 10'd0, 1'b0, 1'b0},
      // one value only: ops do nothing
      '{1'b1, 32'h7FFF_FFFF, OP_ENTER, 1'b1, 32'h7FFF_FFFF, 10'd1, 1'b0, 1'b0},
      '{1'b0, 32'h0000_0000, OP_SUB,   1'b1, 32'h7FFF_FFFF, 10'd1, 1'b0, 1'b0},
      // max + 1 wraps, then min / -1 wraps
      '{1'b1, 32'h0000_0001, OP_ADD,   1'b1, 32'h8000_0000, 10'd1, 1'b1, 1'b0},
      '{1'b1, 32'hFFFF_FFFF, OP_DIV,   1'b1, 32'h8000_0000, 10'd1, 1'b1, 1'b0},
      // divide by zero refused, stack kept
      '{1'b1, 32'h0000_0000, OP_DIV,   1'b1, 32'h0000_0000, 10'd2, 1'b0, 1'b1},
      // unknown operations
      '{1'b0, 32'h0000_0000, OP_RSVD5, 1'b1, 32'h0000_0000, 10'd2, 1'b0, 1'b0},
      '{1'b1, 32'h0000_0003, OP_RSVD6, 1'b1, 32'h0000_0003, 10'd3, 1'b0, 1'b0},
      '{1'b0, 32'h0000_0000, OP_RSVD7, 1'b1, 32'h0000_0003, 10'd3, 1'b0, 1'b0},
      '{1'b0, 32'h0000_0000, OP_SUB,   1'b1, 32'hFFFF_FFFD, 10'd2, 1'b1, 1'b0},
      // remaining rows go through the model
      '{1'b1, 32'hFFFF_FFFF, OP_MUL,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b0, 32'h0000_0000, OP_MUL,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'h8000_0000, OP_ENTER, 1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'h8000_0000, OP_MUL,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'hFFFF_FFF9, OP_ENTER, 1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'h0000_0002, OP_DIV,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'h0000_0007, OP_ENTER, 1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'hFFFF_FFFE, OP_DIV,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'hFFFF_FFFD, OP_DIV,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'h7FFF_FFFF, OP_ENTER, 1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'h7FFF_FFFF, OP_MUL,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'h8000_0000, OP_SUB,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b1, 32'h0000_0000, OP_ADD,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0},
      '{1'b0, 32'h0000_0000, OP_DIV,   1'b0, 32'h0, 10'd0, 1'b0, 1'b0}
   };

   rpn_stack_calculator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // apply one entry to the stack model and return the readout it causes
   function automatic readout_type calc_entry(input key_type k);
      readout_type r;
      logic [31:0] lhs, rhs, mag_l, mag_r, quo, res;
      logic        ok;
      r   = '0;
      res = '0;
      if (k.has_number && stack_fill < STACK_DEPTH) begin
         calc_stack[stack_fill] = k.number;
         stack_fill++;
      end
      if (k.op != OP_ENTER && stack_fill >= 2) begin
         lhs = calc_stack[stack_fill-2];
         rhs = calc_stack[stack_fill-1];
         ok  = 1'b1;
         case (k.op)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            OP_DIV: begin
               if (rhs == '0) begin
                  r.div_by_zero = 1'b1;
                  ok = 1'b0;
               end else begin
                  // unsigned divide of magnitudes, sign from the XOR
                  mag_l = lhs[31] ? -lhs : lhs;
                  mag_r = rhs[31] ? -rhs : rhs;
                  quo   = mag_l / mag_r;
                  res   = (lhs[31] ^ rhs[31]) ? -quo : quo;
               end
            end
            default: ok = 1'b0;
         endcase
         if (ok) begin
            stack_fill--;
            calc_stack[stack_fill-1] = res;
            r.computed = 1'b1;
         end
      end
      r.top   = (stack_fill > 0) ? calc_stack[stack_fill-1] : '0;
      r.depth = stack_fill[9:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s at beat %0d: got %h want %h", what, readouts_seen, got, want);
      error_count++;
   endtask

   // drop valid and idle the request side
   task automatic idle_req(input int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tdata  <= $urandom;
      repeat (n - 1) @(negedge clock);
   endtask

   // offer one entry, wait for its beat, then log what it should produce
   task automatic offer_key(input key_type k, input logic typed, input readout_type want);
      readout_type predicted;
      if (!quiet && $urandom_range(0, 3) == 0)
         idle_req($urandom_range(1, 16));
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= k.number;
      req_tuser  <= {k.op, k.has_number};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      predicted = calc_entry(k);
      expected_readouts.push_back(typed ? want : predicted);
      keys_offered++;
      if (keys_offered >= TOTAL_KEYS - QUIET_KEYS)
         quiet = 1'b1;
   endtask

   // response checker
   always @(posedge clock) begin : check_rsp
      readout_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[41:32], rsp_tdata[42], rsp_tdata[43]};
         if (expected_readouts.size() == 0) begin
            report_mismatch("beat with nothing pending", got.top, '0);
         end else begin
            want = expected_readouts.pop_front();
            if (got.top !== want.top)
               report_mismatch("top_value", got.top, want.top);
            if (got.depth !== want.depth)
               report_mismatch("depth", 32'(got.depth), 32'(want.depth));
            if (got.computed !== want.computed)
               report_mismatch("computed", 32'(got.computed), 32'(want.computed));
            if (got.div_by_zero !== want.div_by_zero)
               report_mismatch("div_by_zero", 32'(got.div_by_zero), 32'(want.div_by_zero));
         end
         readouts_seen++;
      end
   end

   // response side: random ready bursts, one long stall, none at the end
   initial begin : rsp_side
      int  n;
      bit  held;
      held = 1'b0;
      wait (!reset);
      forever begin
         if (!quiet && !held && readouts_seen >= HOLD_AFTER) begin
            held = 1'b1;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 16);
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            n = $urandom_range(1, 24);
            @(negedge clock);
            rsp_tready <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // request side: script, then random entries with one fill-and-drain pass
   initial begin : req_side
      key_type        k;
      readout_type    want;
      script_row_type row;
      int             push_odds;
      bit             filled;
      filled = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (key_script[i]) begin
         row  = key_script[i];
         k    = '{row.has_number, row.number, row.op};
         want = '{row.top, row.depth, row.computed, row.div_by_zero};
         offer_key(k, row.typed, want);
      end

      while (keys_offered < TOTAL_KEYS) begin
         if (!filled && keys_offered >= FILL_AT) begin
            filled = 1'b1;
            // push to full, then mixed entries whose first push gets dropped
            while (stack_fill < STACK_DEPTH)
               offer_key('{1'b1, 32'($urandom), OP_ENTER}, 1'b0, '0);
            repeat (8)
               offer_key('{1'b1, 32'($urandom), 3'($urandom_range(OP_ENTER, OP_DIV))},
                         1'b0, '0);
            // drain with operations only
            while (stack_fill > 4)
               offer_key('{1'b0, 32'($urandom), 3'($urandom_range(OP_ADD, OP_DIV))},
                         1'b0, '0);
            // let every pending response come back before going on
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (expected_readouts.size() != 0) @(posedge clock);
         end

         if ($urandom_range(0, 15) == 0)
            k.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
         else
            k.op = 3'($urandom_range(OP_ENTER, OP_DIV));
         // keep the stack shallow outside the fill pass
         push_odds    = (stack_fill < 4) ? 7 : (stack_fill > 40) ? 2 : 4;
         k.has_number = ($urandom_range(0, 7) < push_odds);
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0:       k.number = 32'h0000_0000;
               1:       k.number = 32'h0000_0001;
               2:       k.number = 32'hFFFF_FFFF;
               3:       k.number = 32'h8000_0000;
               4:       k.number = 32'h7FFF_FFFF;
               default: k.number = 32'($urandom_range(0, 9));
            endcase
         end else begin
            k.number = $urandom;
         end
         if (k.op == OP_DIV && $urandom_range(0, 5) == 0) begin
            k.has_number = 1'b1;
            k.number     = '0;
         end
         offer_key(k, 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS rpn_stack_calculator");
      end else begin
         $display("FAIL rpn_stack_calculator");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #6000000;
      $display("FAIL rpn_stack_calculator");
      $finish;
   end

endmodule

`default_nettype wire
